@@ rtl/core/imp_pkg.sv @@
// ----------------------------------------------------------------------------
// imp_pkg
// Shared types, codes and decode constants of the instruction mix profiler.
// ----------------------------------------------------------------------------
package imp_pkg;

  localparam int CNT_WIDTH_DEF = 32;
  localparam int VALUE_W       = 32;
  localparam int NUM_EVENTS    = 10;
  localparam int NUM_REGS      = 32;
  localparam int EV_IDX_W      = 4;
  localparam int REG_IDX_W     = 5;
  localparam int STAT_IDX_W    = 7;

  localparam logic [STAT_IDX_W-1:0] STAT_READ_BASE  = 7'd10;
  localparam logic [STAT_IDX_W-1:0] STAT_WRITE_BASE = 7'd42;
  localparam logic [STAT_IDX_W-1:0] STAT_END        = 7'd74;

  localparam logic FUNC_RECORD = 1'b0;
  localparam logic FUNC_QUERY  = 1'b1;

  localparam logic [1:0] CLS_NONE = 2'd0;
  localparam logic [1:0] CLS_R    = 2'd1;
  localparam logic [1:0] CLS_I    = 2'd2;
  localparam logic [1:0] CLS_J    = 2'd3;

  localparam logic [2:0] CAT_OTHER  = 3'd0;
  localparam logic [2:0] CAT_ARITH  = 3'd1;
  localparam logic [2:0] CAT_LOAD   = 3'd2;
  localparam logic [2:0] CAT_STORE  = 3'd3;
  localparam logic [2:0] CAT_BRANCH = 3'd4;

  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_FWD  = 2'd1;
  localparam logic [1:0] DIR_BKW  = 2'd2;
  localparam logic [1:0] DIR_NT   = 2'd3;

  localparam int EV_INSTS = 0;
  localparam int EV_R     = 1;
  localparam int EV_I     = 2;
  localparam int EV_J     = 3;
  localparam int EV_FWD   = 4;
  localparam int EV_BKW   = 5;
  localparam int EV_NT    = 6;
  localparam int EV_ARITH = 7;
  localparam int EV_LOAD  = 8;
  localparam int EV_STORE = 9;

  localparam logic [5:0] OP_SPECIAL = 6'd0;
  localparam logic [5:0] OP_J       = 6'd2;
  localparam logic [5:0] OP_JAL     = 6'd3;
  localparam logic [5:0] OP_BEQ     = 6'd4;
  localparam logic [5:0] OP_BNE     = 6'd5;
  localparam logic [5:0] OP_ADDI    = 6'd8;
  localparam logic [5:0] OP_ADDIU   = 6'd9;
  localparam logic [5:0] OP_SLTI    = 6'd10;
  localparam logic [5:0] OP_SLTIU   = 6'd11;
  localparam logic [5:0] OP_ANDI    = 6'd12;
  localparam logic [5:0] OP_ORI     = 6'd13;
  localparam logic [5:0] OP_LUI     = 6'd15;
  localparam logic [5:0] OP_LW      = 6'd35;
  localparam logic [5:0] OP_LBU     = 6'd36;
  localparam logic [5:0] OP_LHU     = 6'd37;
  localparam logic [5:0] OP_SB      = 6'd40;
  localparam logic [5:0] OP_SH      = 6'd41;
  localparam logic [5:0] OP_SW      = 6'd43;

  localparam logic [5:0] FN_SLL  = 6'd0;
  localparam logic [5:0] FN_SRL  = 6'd2;
  localparam logic [5:0] FN_SRA  = 6'd3;
  localparam logic [5:0] FN_JR   = 6'd8;
  localparam logic [5:0] FN_ADD  = 6'd32;
  localparam logic [5:0] FN_ADDU = 6'd33;
  localparam logic [5:0] FN_SUB  = 6'd34;
  localparam logic [5:0] FN_AND  = 6'd36;
  localparam logic [5:0] FN_OR   = 6'd37;
  localparam logic [5:0] FN_XOR  = 6'd38;
  localparam logic [5:0] FN_NOR  = 6'd39;
  localparam logic [5:0] FN_SLT  = 6'd42;
  localparam logic [5:0] FN_SLTU = 6'd43;

  typedef struct packed {
    logic [1:0]           inst_class;
    logic [2:0]           op_category;
    logic [1:0]           branch_dir;
    logic                 rd_a_en;
    logic [REG_IDX_W-1:0] rd_a;
    logic                 rd_b_en;
    logic [REG_IDX_W-1:0] rd_b;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] wr;
  } imp_dec_t;

  function automatic logic r_is_arith(input logic [5:0] fn);
    logic hit;
    hit = (fn == FN_SLL) || (fn == FN_SRL) || (fn == FN_SRA) || (fn == FN_ADD) ||
          (fn == FN_ADDU) || (fn == FN_SUB) || (fn == FN_AND) || (fn == FN_OR) ||
          (fn == FN_XOR) || (fn == FN_NOR) || (fn == FN_SLT) || (fn == FN_SLTU);
    return hit;
  endfunction

endpackage

@@ rtl/core/imp_decode.sv @@
// ----------------------------------------------------------------------------
// imp_decode
// Classify one traced instruction and pick the counters it touches.
// ----------------------------------------------------------------------------
module imp_decode (
  input  logic [31:0]      pc,
  input  logic [31:0]      instruction,
  input  logic [31:0]      next_pc,
  output imp_pkg::imp_dec_t dec
);
  import imp_pkg::*;

  logic [5:0]           op;
  logic [5:0]           fn;
  logic [REG_IDX_W-1:0] rs;
  logic [REG_IDX_W-1:0] rt;
  logic [REG_IDX_W-1:0] rd;
  logic [31:0]          pc_plus4;
  logic                 pc_gt_npc;
  logic                 npc_gt_pc;

  assign op        = instruction[31:26];
  assign rs        = instruction[25:21];
  assign rt        = instruction[20:16];
  assign rd        = instruction[15:11];
  assign fn        = instruction[5:0];
  assign pc_plus4  = pc + 32'd4;
  assign pc_gt_npc = pc > next_pc;
  assign npc_gt_pc = next_pc > pc;

  always_comb begin
    dec = '0;
    dec.inst_class  = CLS_I;
    dec.op_category = CAT_OTHER;
    dec.branch_dir  = DIR_NONE;
    dec.rd_a        = rs;
    dec.rd_b        = rt;
    dec.wr          = rt;
    priority if (op == OP_SPECIAL) begin
      dec.inst_class = CLS_R;
      if (r_is_arith(fn)) begin
        dec.op_category = CAT_ARITH;
      end else if (fn == FN_JR) begin
        dec.op_category = CAT_BRANCH;
        dec.branch_dir  = pc_gt_npc ? DIR_BKW : DIR_FWD;
      end
      dec.rd_a_en = rs != '0;
      dec.rd_b_en = rt != '0;
      dec.wr_en   = 1'b1;
      dec.wr      = rd;
    end else if (op == OP_J || op == OP_JAL) begin
      dec.inst_class  = CLS_J;
      dec.op_category = CAT_BRANCH;
      dec.branch_dir  = npc_gt_pc ? DIR_FWD : DIR_BKW;
    end else begin
      unique case (op)
        OP_ADDI, OP_ADDIU, OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI: begin
          dec.op_category = CAT_ARITH;
          dec.wr_en       = 1'b1;
          dec.rd_a_en     = 1'b1;
        end
        OP_LUI: begin
          dec.op_category = CAT_LOAD;
          dec.wr_en       = 1'b1;
        end
        OP_LW, OP_LBU, OP_LHU: begin
          dec.op_category = CAT_LOAD;
          dec.wr_en       = 1'b1;
          dec.rd_a_en     = 1'b1;
        end
        OP_SB, OP_SH, OP_SW: begin
          dec.op_category = CAT_STORE;
          dec.wr_en       = 1'b1;
          dec.rd_a_en     = 1'b1;
        end
        OP_BEQ, OP_BNE: begin
          dec.op_category = CAT_BRANCH;
          dec.rd_a_en     = 1'b1;
          dec.rd_b_en     = 1'b1;
          if (next_pc == pc_plus4) begin
            dec.branch_dir = DIR_NT;
          end else begin
            dec.branch_dir = pc_gt_npc ? DIR_BKW : DIR_FWD;
          end
        end
        default: begin
          dec.op_category = CAT_OTHER;
        end
      endcase
    end
  end

endmodule

@@ rtl/core/imp_counters.sv @@
// ----------------------------------------------------------------------------
// imp_counters
// Saturating event and per-register counters with a single query port.
// ----------------------------------------------------------------------------
module imp_counters #(
  parameter int COUNTER_WIDTH = imp_pkg::CNT_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               upd,
  input  imp_pkg::imp_dec_t                  dec,
  input  logic [imp_pkg::STAT_IDX_W-1:0]     stat_index,
  output logic [imp_pkg::VALUE_W-1:0]        query_value
);
  import imp_pkg::*;

  logic [COUNTER_WIDTH-1:0]  ev_val [NUM_EVENTS];
  logic [COUNTER_WIDTH-1:0]  rd_val [NUM_REGS];
  logic [COUNTER_WIDTH-1:0]  wr_val [NUM_REGS];
  logic [NUM_EVENTS-1:0]     ev_inc;
  logic [STAT_IDX_W-1:0]     rd_off;
  logic [STAT_IDX_W-1:0]     wr_off;
  logic [COUNTER_WIDTH-1:0]  sel;

  always_comb begin
    ev_inc           = '0;
    ev_inc[EV_INSTS] = 1'b1;
    ev_inc[EV_R]     = dec.inst_class == CLS_R;
    ev_inc[EV_I]     = dec.inst_class == CLS_I;
    ev_inc[EV_J]     = dec.inst_class == CLS_J;
    ev_inc[EV_FWD]   = dec.branch_dir == DIR_FWD;
    ev_inc[EV_BKW]   = dec.branch_dir == DIR_BKW;
    ev_inc[EV_NT]    = dec.branch_dir == DIR_NT;
    ev_inc[EV_ARITH] = dec.op_category == CAT_ARITH;
    ev_inc[EV_LOAD]  = dec.op_category == CAT_LOAD;
    ev_inc[EV_STORE] = dec.op_category == CAT_STORE;
  end

  for (genvar i = 0; i < NUM_EVENTS; i++) begin : g_ev
    logic [COUNTER_WIDTH-1:0] cnt;
    logic [COUNTER_WIDTH:0]   sum;
    assign sum       = {1'b0, cnt} + (COUNTER_WIDTH+1)'(ev_inc[i]);
    assign ev_val[i] = cnt;
    always_ff @(posedge clk) begin
      if (rst) begin
        cnt <= '0;
      end else if (upd && ev_inc[i] && !sum[COUNTER_WIDTH]) begin
        cnt <= sum[COUNTER_WIDTH-1:0];
      end
    end
  end

  for (genvar i = 0; i < NUM_REGS; i++) begin : g_reg
    logic [COUNTER_WIDTH-1:0] rcnt;
    logic [COUNTER_WIDTH-1:0] wcnt;
    logic [COUNTER_WIDTH:0]   rsum;
    logic [COUNTER_WIDTH:0]   wsum;
    logic                     a_hit;
    logic                     b_hit;
    logic                     w_hit;
    logic [1:0]               rinc;
    assign a_hit     = dec.rd_a_en && (dec.rd_a == REG_IDX_W'(i));
    assign b_hit     = dec.rd_b_en && (dec.rd_b == REG_IDX_W'(i));
    assign w_hit     = dec.wr_en && (dec.wr == REG_IDX_W'(i));
    assign rinc      = {1'b0, a_hit} + {1'b0, b_hit};
    assign rsum      = {1'b0, rcnt} + (COUNTER_WIDTH+1)'(rinc);
    assign wsum      = {1'b0, wcnt} + (COUNTER_WIDTH+1)'(w_hit);
    assign rd_val[i] = rcnt;
    assign wr_val[i] = wcnt;
    always_ff @(posedge clk) begin
      if (rst) begin
        rcnt <= '0;
      end else if (upd && (rinc != 2'd0)) begin
        rcnt <= rsum[COUNTER_WIDTH] ? '1 : rsum[COUNTER_WIDTH-1:0];
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        wcnt <= '0;
      end else if (upd && w_hit && !wsum[COUNTER_WIDTH]) begin
        wcnt <= wsum[COUNTER_WIDTH-1:0];
      end
    end
  end

  assign rd_off = stat_index - STAT_READ_BASE;
  assign wr_off = stat_index - STAT_WRITE_BASE;

  always_comb begin
    priority if (stat_index < STAT_READ_BASE) begin
      sel = ev_val[stat_index[EV_IDX_W-1:0]];
    end else if (stat_index < STAT_WRITE_BASE) begin
      sel = rd_val[rd_off[REG_IDX_W-1:0]];
    end else if (stat_index < STAT_END) begin
      sel = wr_val[wr_off[REG_IDX_W-1:0]];
    end else begin
      sel = '0;
    end
  end

  if (COUNTER_WIDTH > VALUE_W) begin : g_clip
    assign query_value = (|sel[COUNTER_WIDTH-1:VALUE_W]) ? '1 : sel[VALUE_W-1:0];
  end else begin : g_ext
    assign query_value = VALUE_W'(sel);
  end

  a_insts_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> ev_val[EV_INSTS] >= $past(ev_val[EV_INSTS]))
    else $error("instruction count decreased");

  a_hold_without_update: assert property (@(posedge clk) disable iff (rst)
    !upd |=> $stable(ev_val[EV_INSTS]) && $stable(ev_val[EV_R]) &&
             $stable(rd_val[0]) && $stable(wr_val[0]))
    else $error("counter changed without an update");

endmodule

@@ rtl/core/instruction_mix_profiler.sv @@
// ----------------------------------------------------------------------------
// instruction_mix_profiler
// MIPS32 instruction mix profiler: classify traced instructions, keep
// saturating event and per-register counters, answer counter queries.
//
//   channel | handshake           | payload
//   --------+---------------------+-------------------------------------------
//   in      | in_valid / in_stall | func, pc, instruction, next_pc, stat_index
//   out     | out_valid/out_stall | inst_class, op_category, branch_dir,
//           |                     | counter_value
//
// One beat in, one beat out; throughput one beat per cycle while the result is not stalled.
// Each beat passes the input register, then decode and counter update into
// the result register.
// Reset clears all counters and both valid flags.
// A stalled result holds; a held input beat waits behind it, one more beat
// is taken while the result waits.
// ----------------------------------------------------------------------------
module instruction_mix_profiler #(
  parameter int COUNTER_WIDTH = imp_pkg::CNT_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           func,
  input  logic [31:0]                    pc,
  input  logic [31:0]                    instruction,
  input  logic [31:0]                    next_pc,
  input  logic [imp_pkg::STAT_IDX_W-1:0] stat_index,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     inst_class,
  output logic [2:0]                     op_category,
  output logic [1:0]                     branch_dir,
  output logic [imp_pkg::VALUE_W-1:0]    counter_value
);
  import imp_pkg::*;

  logic                  s1_valid;
  logic                  s1_func;
  logic [31:0]           s1_pc;
  logic [31:0]           s1_instr;
  logic [31:0]           s1_npc;
  logic [STAT_IDX_W-1:0] s1_idx;
  logic                  s1_adv;
  logic                  in_take;
  logic                  upd;
  imp_dec_t              dec;
  logic [VALUE_W-1:0]    query_value;

  assign s1_adv   = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_adv;
  assign in_take  = in_valid && !in_stall;
  assign upd      = s1_adv && (s1_func == FUNC_RECORD);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_func  <= func;
      s1_pc    <= pc;
      s1_instr <= instruction;
      s1_npc   <= next_pc;
      s1_idx   <= stat_index;
    end
  end

  imp_decode u_decode (
    .pc          (s1_pc),
    .instruction (s1_instr),
    .next_pc     (s1_npc),
    .dec         (dec)
  );

  imp_counters #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_counters (
    .clk         (clk),
    .rst         (rst),
    .upd         (upd),
    .dec         (dec),
    .stat_index  (s1_idx),
    .query_value (query_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      if (s1_func == FUNC_QUERY) begin
        inst_class    <= CLS_NONE;
        op_category   <= CAT_OTHER;
        branch_dir    <= DIR_NONE;
        counter_value <= query_value;
      end else begin
        inst_class    <= dec.inst_class;
        op_category   <= dec.op_category;
        branch_dir    <= dec.branch_dir;
        counter_value <= '0;
      end
    end
  end

  a_advance_fills_output: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> out_valid)
    else $error("advanced beat did not reach the result register");

  a_record_zero_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && (inst_class != CLS_NONE) |-> counter_value == '0)
    else $error("record beat carries a counter value");

  a_no_accept_when_full: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && out_stall |-> !in_take)
    else $error("beat taken while both stages are held");

endmodule
